@@ rtl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the deque unit: command kinds, the result
// record and the sequencer states.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int KIND_W = 4;
    localparam int WORD_W = 32;

    // command kinds
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 4'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 4'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 4'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 4'd4;
    localparam logic [KIND_W-1:0] KIND_DELETE     = 4'd5;
    localparam logic [KIND_W-1:0] KIND_PRINT_ALL  = 4'd6;
    localparam logic [KIND_W-1:0] KIND_PRINT_HEAD = 4'd7;
    localparam logic [KIND_W-1:0] KIND_PRINT_TAIL = 4'd8;

    // one result record
    typedef struct packed {
        logic signed [WORD_W-1:0] item_value;
        logic                     is_last;
        logic                     is_empty_run;
    } out_item_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DEL   = 4'b0010,
        ST_PRINT = 4'b0100,
        ST_EMPTY = 4'b1000
    } deq_state_t;

endpackage

@@ rtl/deq_mem.sv @@
// ----------------------------------------------------------------------------
// deq_mem
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module deq_mem #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [deq_pkg::WORD_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [deq_pkg::WORD_W-1:0] rd_data
);

    logic [deq_pkg::WORD_W-1:0] mem_array [DEPTH];
    logic [deq_pkg::WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/deq_outq.sv @@
// ----------------------------------------------------------------------------
// deq_outq
// Two-entry result queue between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module deq_outq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    input  deq_pkg::out_item_t push_item,
    input  logic               pop_ready,
    output logic               out_valid,
    output deq_pkg::out_item_t out_item,
    output logic [1:0]         count
);

    deq_pkg::out_item_t entry_reg [2];
    logic               wr_ptr_reg;
    logic               wr_ptr_next;
    logic               rd_ptr_reg;
    logic               rd_ptr_next;
    logic [1:0]         cnt_reg;
    logic [1:0]         cnt_next;
    logic               pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign count     = cnt_reg;
    assign pop       = out_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push_valid ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push_valid} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/deque_with_value_delete_unit.sv @@
// ----------------------------------------------------------------------------
// deque_with_value_delete_unit
// Bounded double-ended queue of signed words held in a circular store,
// with push/pop at both ends, clear, delete-by-value with compaction and
// print runs (all, first N, last N).
// ----------------------------------------------------------------------------
//
//  channel  | direction | ports                                   | carries
//  ---------+-----------+-----------------------------------------+---------------
//  command  | in        | s_valid s_ready s_kind s_operand        | one command
//  result   | out       | m_valid m_ready m_item_value m_is_last  | one element
//           |           | m_is_empty_run                          | of a print run
//
//  push, pop and clear act without leaving the idle state; delete walks the store
//  through the single memory read port; a print run reads through it as well and an
//  empty run gives a single marker result; the read port (one entry per cycle,
//  in a print only while the result queue has room) sets the walk rate
//  reset clears head, occupancy and the sequencer; the store itself is not
//  cleared, only occupied entries are ever read
//  a stalled result channel holds back reads through the two-entry result
//  queue; commands are taken only while the sequencer is idle
// ----------------------------------------------------------------------------
module deque_with_value_delete_unit #(
    parameter int CAPACITY = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // command channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [deq_pkg::KIND_W-1:0]        s_kind,
    input  logic signed [deq_pkg::WORD_W-1:0] s_operand,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [deq_pkg::WORD_W-1:0] m_item_value,
    output logic                              m_is_last,
    output logic                              m_is_empty_run
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(CAPACITY);
    localparam logic [IDX_W:0]   CAP_SUM   = (IDX_W + 1)'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPACITY - 1);

    // circular slot of a position counted from the head
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [IDX_W-1:0] pos);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= CAP_SUM) begin
            sum = sum - CAP_SUM;
        end
        return sum[IDX_W-1:0];
    endfunction

    // sequencer and queue state
    deq_pkg::deq_state_t        state_reg, state_next;
    logic [IDX_W-1:0]           head_reg, head_next;
    logic [CNT_W-1:0]           occ_reg, occ_next;
    // walk counters
    logic [CNT_W-1:0]           rd_pos_reg, rd_pos_next;
    logic [CNT_W-1:0]           rem_reg, rem_next;
    logic [CNT_W-1:0]           kept_reg, kept_next;
    logic                       inflight_reg, inflight_next;
    logic                       inflight_last_reg, inflight_last_next;
    logic [deq_pkg::WORD_W-1:0] op_val_reg, op_val_next;

    // memory port
    logic                       mem_we;
    logic [IDX_W-1:0]           mem_waddr;
    logic [deq_pkg::WORD_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [IDX_W-1:0]           mem_raddr;
    logic [deq_pkg::WORD_W-1:0] mem_rdata;

    // result queue
    logic                       q_push;
    deq_pkg::out_item_t         q_item;
    logic                       q_valid;
    deq_pkg::out_item_t         q_out;
    logic [1:0]                 q_cnt;
    logic                       q_pop;
    logic                       q_credit;

    // print count decode
    logic                       full;
    logic                       op_big;
    logic [CNT_W-1:0]           clamp_cnt;
    logic [CNT_W-1:0]           run_cnt;
    logic [CNT_W-1:0]           run_start;
    logic [IDX_W-1:0]           head_dec;
    logic [IDX_W-1:0]           head_inc;

    assign s_ready = (state_reg == deq_pkg::ST_IDLE);
    assign full    = (occ_reg == CAP_CNT);
    assign op_big  = ($unsigned(s_operand) > {{(deq_pkg::WORD_W-CNT_W){1'b0}}, occ_reg});
    assign head_dec = (head_reg == '0) ? LAST_SLOT : head_reg - 1'b1;
    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;

    always_comb begin
        if (s_operand[deq_pkg::WORD_W-1]) begin
            clamp_cnt = '0;
        end else if (op_big) begin
            clamp_cnt = occ_reg;
        end else begin
            clamp_cnt = s_operand[CNT_W-1:0];
        end
        run_cnt   = (s_kind == deq_pkg::KIND_PRINT_ALL) ? occ_reg : clamp_cnt;
        run_start = (s_kind == deq_pkg::KIND_PRINT_TAIL) ? occ_reg - run_cnt : '0;
    end

    // a read may issue only if its data is sure to find room in the queue
    assign q_pop    = q_valid && m_ready;
    assign q_credit = ({1'b0, q_cnt} + {2'b00, inflight_reg} + 3'd1) <= (3'd2 + {2'b00, q_pop});

    always_comb begin
        state_next         = state_reg;
        head_next          = head_reg;
        occ_next           = occ_reg;
        rd_pos_next        = rd_pos_reg;
        rem_next           = rem_reg;
        kept_next          = kept_reg;
        inflight_next      = 1'b0;
        inflight_last_next = inflight_last_reg;
        op_val_next        = op_val_reg;
        mem_we             = 1'b0;
        mem_waddr          = '0;
        mem_wdata          = s_operand;
        mem_re             = 1'b0;
        mem_raddr          = '0;
        q_push             = 1'b0;
        q_item             = '0;

        case (state_reg)
            deq_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (s_kind)
                        deq_pkg::KIND_PUSH_FRONT: begin
                            if (!full) begin
                                head_next = head_dec;
                                mem_we    = 1'b1;
                                mem_waddr = head_dec;
                                occ_next  = occ_reg + 1'b1;
                            end
                        end
                        deq_pkg::KIND_PUSH_BACK: begin
                            if (!full) begin
                                mem_we    = 1'b1;
                                mem_waddr = slot_of(head_reg, occ_reg[IDX_W-1:0]);
                                occ_next  = occ_reg + 1'b1;
                            end
                        end
                        deq_pkg::KIND_POP_FRONT: begin
                            if (occ_reg != '0) begin
                                head_next = head_inc;
                                occ_next  = occ_reg - 1'b1;
                            end
                        end
                        deq_pkg::KIND_POP_BACK: begin
                            if (occ_reg != '0) begin
                                occ_next = occ_reg - 1'b1;
                            end
                        end
                        deq_pkg::KIND_CLEAR: begin
                            occ_next = '0;
                        end
                        deq_pkg::KIND_DELETE: begin
                            // walk all entries, write back the survivors packed
                            rd_pos_next = '0;
                            rem_next    = occ_reg;
                            kept_next   = '0;
                            op_val_next = s_operand;
                            state_next  = deq_pkg::ST_DEL;
                        end
                        deq_pkg::KIND_PRINT_ALL,
                        deq_pkg::KIND_PRINT_HEAD,
                        deq_pkg::KIND_PRINT_TAIL: begin
                            rd_pos_next = run_start;
                            rem_next    = run_cnt;
                            if (run_cnt == '0) begin
                                state_next = deq_pkg::ST_EMPTY;
                            end else begin
                                state_next = deq_pkg::ST_PRINT;
                            end
                        end
                        default: begin
                            // unknown kind, ignored
                        end
                    endcase
                end
            end

            deq_pkg::ST_DEL: begin
                if (rem_reg != '0) begin
                    mem_re      = 1'b1;
                    mem_raddr   = slot_of(head_reg, rd_pos_reg[IDX_W-1:0]);
                    rd_pos_next = rd_pos_reg + 1'b1;
                    rem_next    = rem_reg - 1'b1;
                    inflight_next = 1'b1;
                end
                // write slot never runs ahead of the read slot
                if (inflight_reg && (mem_rdata != op_val_reg)) begin
                    mem_we    = 1'b1;
                    mem_waddr = slot_of(head_reg, kept_reg[IDX_W-1:0]);
                    mem_wdata = mem_rdata;
                    kept_next = kept_reg + 1'b1;
                end
                if ((rem_reg == '0) && !inflight_reg) begin
                    occ_next   = kept_reg;
                    state_next = deq_pkg::ST_IDLE;
                end
            end

            deq_pkg::ST_PRINT: begin
                if ((rem_reg != '0) && q_credit) begin
                    mem_re             = 1'b1;
                    mem_raddr          = slot_of(head_reg, rd_pos_reg[IDX_W-1:0]);
                    rd_pos_next        = rd_pos_reg + 1'b1;
                    rem_next           = rem_reg - 1'b1;
                    inflight_next      = 1'b1;
                    inflight_last_next = (rem_reg == CNT_W'(1));
                end
                if (inflight_reg) begin
                    q_push            = 1'b1;
                    q_item.item_value = mem_rdata;
                    q_item.is_last    = inflight_last_reg;
                end
                if ((rem_reg == '0) && !inflight_reg) begin
                    state_next = deq_pkg::ST_IDLE;
                end
            end

            deq_pkg::ST_EMPTY: begin
                // single marker result for a run with no element
                if (q_cnt != 2'd2) begin
                    q_push              = 1'b1;
                    q_item.is_last      = 1'b1;
                    q_item.is_empty_run = 1'b1;
                    state_next          = deq_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = deq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= deq_pkg::ST_IDLE;
            head_reg     <= '0;
            occ_reg      <= '0;
            rd_pos_reg   <= '0;
            rem_reg      <= '0;
            kept_reg     <= '0;
            inflight_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            occ_reg      <= occ_next;
            rd_pos_reg   <= rd_pos_next;
            rem_reg      <= rem_next;
            kept_reg     <= kept_next;
            inflight_reg <= inflight_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        inflight_last_reg <= inflight_last_next;
        op_val_reg        <= op_val_next;
    end

    deq_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    deq_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push),
        .push_item  (q_item),
        .pop_ready  (m_ready),
        .out_valid  (q_valid),
        .out_item   (q_out),
        .count      (q_cnt)
    );

    assign m_valid        = q_valid;
    assign m_item_value   = q_out.item_value;
    assign m_is_last      = q_out.is_last;
    assign m_is_empty_run = q_out.is_empty_run;

endmodule
